>>> rtl/vma_pkg.sv
// ============================================================================
// vma_pkg: shared types and constants for the vector moving average
// Sample and result layouts, window sizing, register indexes and the
// request layout of the serial divider.
// ============================================================================
`default_nettype none

package vma_pkg;

  // Window and sample sizing
  localparam int SAMPLE_BITS = 16;
  localparam int WINDOW_MAX  = 64;
  localparam int SLOT_BITS   = $clog2(WINDOW_MAX);
  localparam int LEN_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int AXES        = 3;
  localparam int AXIS_BITS   = 2;

  // Running sum widths: plain sum of N samples, weighted sum up to N(N+1)/2 times a sample
  localparam int PLAIN_BITS  = SAMPLE_BITS + SLOT_BITS;
  localparam int DIVR_MAX    = WINDOW_MAX * (WINDOW_MAX + 1) / 2;
  localparam int DIVR_BITS   = $clog2(DIVR_MAX + 1);
  localparam int WSUM_BITS   = SAMPLE_BITS + DIVR_BITS;
  localparam int PROD_BITS   = LEN_BITS + SAMPLE_BITS + 1;
  localparam int QCNT_BITS   = $clog2(SAMPLE_BITS);

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 7;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHTED_MODE = CFG_INDEX_BITS'(1);
  localparam logic [LEN_BITS-1:0]       LEN_RESET         = LEN_BITS'(8);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] avg_x;
    logic signed [SAMPLE_BITS-1:0] avg_y;
    logic signed [SAMPLE_BITS-1:0] avg_z;
  } avg_t;

  // Start of one division in the serial divider
  typedef struct packed {
    logic                        start;
    logic signed [WSUM_BITS-1:0] dividend;
    logic [DIVR_BITS-1:0]        divisor;
  } div_req_t;

endpackage

`default_nettype wire

>>> rtl/vma_div.sv
// ============================================================================
// vma_div: bit-serial signed divider
// Restoring division of a signed running sum by a positive window divisor,
// one quotient bit per cycle through a shift register; truncates toward zero.
// ============================================================================
`default_nettype none

module vma_div import vma_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire div_req_t                      req,
  output logic                               done,
  output logic signed [SAMPLE_BITS-1:0]      quotient
);

  logic                   busy_r;
  logic                   done_r;
  logic                   neg_r;
  logic [QCNT_BITS-1:0]   cnt_r;
  logic [DIVR_BITS-1:0]   rem_r;
  logic [DIVR_BITS-1:0]   divisor_r;
  logic [SAMPLE_BITS-1:0] shift_r;

  logic [WSUM_BITS-1:0]   mag;
  logic [DIVR_BITS:0]     trial;
  logic [DIVR_BITS:0]     diff;
  logic                   fits;

  // Take the magnitude; the quotient is known to fit SAMPLE_BITS bits,
  // so the upper part of the magnitude already sits below the divisor
  assign mag   = req.dividend[WSUM_BITS-1] ? WSUM_BITS'(-req.dividend)
                                           : WSUM_BITS'(req.dividend);
  assign trial = {rem_r, shift_r[SAMPLE_BITS-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign fits  = trial >= {1'b0, divisor_r};

  // Sequence the quotient bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == QCNT_BITS'(SAMPLE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + QCNT_BITS'(1);
        end
      end
    end
  end

  // Shift dividend bits out and quotient bits in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= mag[WSUM_BITS-1:SAMPLE_BITS];
      shift_r   <= mag[SAMPLE_BITS-1:0];
      neg_r     <= req.dividend[WSUM_BITS-1];
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r   <= fits ? diff[DIVR_BITS-1:0] : trial[DIVR_BITS-1:0];
      shift_r <= {shift_r[SAMPLE_BITS-2:0], fits};
    end
  end

  // Restore the sign
  assign done     = done_r;
  assign quotient = neg_r ? SAMPLE_BITS'(-shift_r) : shift_r;

endmodule

`default_nettype wire

>>> rtl/vector_moving_average.sv
// ============================================================================
// vector_moving_average: three-axis plain or weighted moving average
// Keeps the last N samples in a window store, updates running plain and
// weighted sums per axis and divides one axis after the other in a
// bit-serial divider.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data   (sample_t)
//   out      output     out_valid / out_ready  out_data  (avg_t)
//   cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// A request passes from acceptance through multiply, sum update, three
// divisions in the shared serial divider and the output load; the window
// read overlaps the accept. The next request is accepted in the cycle after
// the load. One request is in work at a time; the next is accepted once
// the result sits in the output register, even while that result still
// waits. Reset and writes to the window length or mode register clear the
// window through per-slot valid bits; no clearing pass is needed.
// ============================================================================
`default_nettype none

module vector_moving_average import vma_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire sample_t                   in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output avg_t                           out_data,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIVS = 3'd3;
  localparam logic [2:0] ST_DIVW = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [AXIS_BITS-1:0]        axis_r, axis_nxt;
  logic [LEN_BITS-1:0]         len_r;
  logic                        mode_r;
  logic [SLOT_BITS-1:0]        write_slot_r;
  logic [WINDOW_MAX-1:0]       valid_r;
  logic                        valid_q_r;
  sample_t                     sample_r;
  sample_t                     mem_q_r;
  sample_t                     mem [WINDOW_MAX];
  logic signed [PLAIN_BITS-1:0] plain_r [AXES];
  logic signed [WSUM_BITS-1:0]  wsum_r  [AXES];
  logic signed [WSUM_BITS-1:0]  prod_r  [AXES];
  logic signed [SAMPLE_BITS-1:0] res_r  [AXES];
  logic [DIVR_BITS-1:0]        divisor_r;
  logic                        out_valid_r;
  avg_t                        out_data_r;

  logic                        in_fire;
  logic                        cfg_clear;
  logic [LEN_BITS-1:0]         cfg_len;
  logic [SLOT_BITS-1:0]        cur_slot;
  logic [LEN_BITS-1:0]         slot_p1;
  logic [SLOT_BITS-1:0]        next_slot;
  logic                        out_load;
  logic [2*LEN_BITS-1:0]       len_ext;
  logic [2*LEN_BITS-1:0]       tri_num;
  logic signed [SAMPLE_BITS-1:0] fresh  [AXES];
  logic signed [SAMPLE_BITS-1:0] oldest [AXES];
  div_req_t                    div_req;
  logic                        div_done;
  logic signed [SAMPLE_BITS-1:0] div_q;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Clamp the window length into 1..WINDOW_MAX
  assign cfg_clear = cfg_we && (cfg_index == REG_WINDOW_LENGTH ||
                                cfg_index == REG_WEIGHTED_MODE);
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_len = LEN_BITS'(1);
    end else if (int'(cfg_wdata) > WINDOW_MAX) begin
      cfg_len = LEN_BITS'(WINDOW_MAX);
    end else begin
      cfg_len = LEN_BITS'(cfg_wdata);
    end
  end

  // Pick the slot of the oldest sample and the one after it
  assign cur_slot  = (LEN_BITS'(write_slot_r) >= len_r) ? '0 : write_slot_r;
  assign slot_p1   = LEN_BITS'(cur_slot) + LEN_BITS'(1);
  assign next_slot = (slot_p1 >= len_r) ? '0 : SLOT_BITS'(slot_p1);

  // Divisor: N, or N(N+1)/2 in weighted mode
  assign len_ext = (2*LEN_BITS)'(len_r);
  assign tri_num = len_ext * (len_ext + (2*LEN_BITS)'(1));

  // Split the request and the stored entry into axes
  assign fresh[0]  = sample_r.sample_x;
  assign fresh[1]  = sample_r.sample_y;
  assign fresh[2]  = sample_r.sample_z;
  assign oldest[0] = valid_q_r ? mem_q_r.sample_x : '0;
  assign oldest[1] = valid_q_r ? mem_q_r.sample_y : '0;
  assign oldest[2] = valid_q_r ? mem_q_r.sample_z : '0;

  // Sequence one request
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ST_DIVS;
        axis_nxt  = '0;
      end
      ST_DIVS: begin
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          if (axis_r == AXIS_BITS'(AXES - 1)) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_DIVS;
            axis_nxt  = axis_r + AXIS_BITS'(1);
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state, registers, slot pointer and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      axis_r       <= '0;
      len_r        <= LEN_RESET;
      mode_r       <= 1'b0;
      write_slot_r <= '0;
      out_valid_r  <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        plain_r[a] <= '0;
        wsum_r[a]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      if (cfg_we && cfg_index == REG_WINDOW_LENGTH) begin
        len_r <= cfg_len;
      end
      if (cfg_we && cfg_index == REG_WEIGHTED_MODE) begin
        mode_r <= cfg_wdata[0];
      end
      if (cfg_clear) begin
        write_slot_r <= '0;
        for (int a = 0; a < AXES; a++) begin
          plain_r[a] <= '0;
          wsum_r[a]  <= '0;
        end
      end else if (state_r == ST_UPD) begin
        // Every weight drops by one, the oldest leaves, the newest enters at N
        for (int a = 0; a < AXES; a++) begin
          wsum_r[a]  <= wsum_r[a] - WSUM_BITS'(plain_r[a]) + prod_r[a];
          plain_r[a] <= plain_r[a] - PLAIN_BITS'(oldest[a]) + PLAIN_BITS'(fresh[a]);
        end
      end
      if (out_load) begin
        write_slot_r <= next_slot;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Mark written slots; reset and register writes drop them all
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      valid_r   <= '0;
      valid_q_r <= 1'b0;
    end else begin
      if (in_fire) begin
        valid_q_r <= valid_r[cur_slot];
      end
      if (state_r == ST_UPD) begin
        valid_r[cur_slot] <= 1'b1;
      end
    end
  end

  // Window store: read the oldest entry on accept, overwrite it on update
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_q_r <= mem[cur_slot];
    end
    if (state_r == ST_UPD) begin
      mem[cur_slot] <= sample_r;
    end
  end

  // Capture the request, form products and the divisor
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_data;
    end
    if (state_r == ST_MUL) begin
      for (int a = 0; a < AXES; a++) begin
        prod_r[a] <= WSUM_BITS'(PROD_BITS'($signed({1'b0, len_r})) *
                                PROD_BITS'(fresh[a]));
      end
      divisor_r <= mode_r ? DIVR_BITS'(tri_num >> 1) : DIVR_BITS'(len_r);
    end
    if (state_r == ST_DIVW && div_done) begin
      res_r[axis_r] <= div_q;
    end
    if (out_load) begin
      out_data_r.avg_x <= res_r[0];
      out_data_r.avg_y <= res_r[1];
      out_data_r.avg_z <= res_r[2];
    end
  end

  // Divide the selected axis
  assign div_req.start    = (state_r == ST_DIVS);
  assign div_req.dividend = mode_r ? wsum_r[axis_r] : WSUM_BITS'(plain_r[axis_r]);
  assign div_req.divisor  = divisor_r;

  vma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIVW)
    else $error("divider finished outside the wait state");

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_BITS'(write_slot_r) < len_r)
    else $error("write slot beyond window length");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r != '0 && int'(len_r) <= WINDOW_MAX)
    else $error("window length out of range");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench for vector_moving_average
// Streams three-axis samples through the block under random input gaps and
// output stalls, predicts each plain or weighted mean from its own copy of the
// window and running sums, and compares every result field by field.
// ============================================================================

module tb;
  import vma_pkg::*;

  localparam int                        WATCHDOG_LIMIT = 20000;
  localparam int                        DRAIN_CYCLES   = 100;
  localparam int                        REPORT_LIMIT   = 10;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_2   = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_3   = CFG_INDEX_BITS'(3);
  localparam logic [CFG_DATA_BITS-1:0]  MODE_PLAIN     = CFG_DATA_BITS'(0);
  localparam logic [CFG_DATA_BITS-1:0]  MODE_WEIGHTED  = CFG_DATA_BITS'(1);
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  sample_t                   in_data;
  logic                      out_valid;
  logic                      out_ready;
  avg_t                      out_data;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  // Idle percentages for the request sender and the result receiver
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  avg_t expected_averages[$];
  int   mismatch_count = 0;
  int   stall_cycles   = 0;

  // Predictor state: registers, window and running sums per axis
  int unsigned win_len;
  bit          wmode;
  longint      sample_window [WINDOW_MAX][AXES];
  int unsigned next_slot;
  longint      plain_sums [AXES];
  longint      weighted_sums [AXES];

  vector_moving_average dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_window();
    for (int s = 0; s < WINDOW_MAX; s++) begin
      for (int a = 0; a < AXES; a++) begin
        sample_window[s][a] = 0;
      end
    end
    for (int a = 0; a < AXES; a++) begin
      plain_sums[a]    = 0;
      weighted_sums[a] = 0;
    end
    next_slot = 0;
  endfunction

  // Mirror a register write; unknown indexes leave everything alone
  function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] index,
                                         input logic [CFG_DATA_BITS-1:0] value);
    if (index == REG_WINDOW_LENGTH) begin
      if (value == 0) begin
        win_len = 1;
      end else if (value > WINDOW_MAX) begin
        win_len = WINDOW_MAX;
      end else begin
        win_len = value;
      end
      clear_window();
    end else if (index == REG_WEIGHTED_MODE) begin
      wmode = value[0];
      clear_window();
    end
  endfunction

  // Push one sample into the window and return the mean per axis
  function automatic avg_t predict_average(input sample_t s);
    longint      fresh [AXES];
    longint      mean [AXES];
    longint      n;
    int unsigned slot;
    avg_t        r;
    fresh[0] = s.sample_x;
    fresh[1] = s.sample_y;
    fresh[2] = s.sample_z;
    n = win_len;
    slot = next_slot;
    if (slot >= win_len) begin
      slot = 0;
    end
    for (int a = 0; a < AXES; a++) begin
      // older weights drop by one as the oldest leaves; the newest enters at N
      weighted_sums[a] = weighted_sums[a] - plain_sums[a] + n * fresh[a];
      plain_sums[a]    = plain_sums[a] - sample_window[slot][a] + fresh[a];
      sample_window[slot][a] = fresh[a];
      if (wmode) begin
        mean[a] = weighted_sums[a] / ((n * (n + 1)) / 2);
      end else begin
        mean[a] = plain_sums[a] / n;
      end
    end
    next_slot = (slot + 1 >= win_len) ? 0 : slot + 1;
    r.avg_x = 16'(mean[0]);
    r.avg_y = 16'(mean[1]);
    r.avg_z = 16'(mean[2]);
    return r;
  endfunction

  // ----------------------------------------------------------------- drivers

  // Send one request; valid stays up after acceptance until the next call
  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    expected_averages.push_back(predict_average(s));
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_averages.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] value);
    settle_block();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    apply_register(index, value);
  endtask

  // Result receiver: stall at random
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ----------------------------------------------------------------- checker

  task automatic report_mismatch(input string what, input avg_t want, input avg_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch (%s) at %0t: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
               what, $realtime, want.avg_x, want.avg_y, want.avg_z,
               got.avg_x, got.avg_y, got.avg_z);
    end
  endtask

  always @(posedge clk) begin : check_results
    avg_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_averages.size() == 0) begin
        report_mismatch("no request pending", '0, out_data);
      end else begin
        want = expected_averages.pop_front();
        if (out_data.avg_x !== want.avg_x || out_data.avg_y !== want.avg_y ||
            out_data.avg_z !== want.avg_z) begin
          report_mismatch("field value", want, out_data);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [SAMPLE_BITS-1:0] random_axis(input int style);
    case (style)
      0: return S_MAX;
      1: return S_MIN;
      2: return SAMPLE_BITS'($urandom_range(64) - 32);
      default: begin
        case ($urandom_range(9))
          0:       return S_MAX;
          1:       return S_MIN;
          2, 3:    return SAMPLE_BITS'($urandom_range(64) - 32);
          default: return SAMPLE_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic sample_t random_sample(input int style);
    sample_t s;
    s.sample_x = random_axis(style);
    s.sample_y = random_axis(style);
    s.sample_z = random_axis(style);
    return s;
  endfunction

  // Favor the window length corners, including zero and values past the top
  function automatic logic [CFG_DATA_BITS-1:0] pick_window_length();
    case ($urandom_range(7))
      0:       return CFG_DATA_BITS'(0);
      1:       return CFG_DATA_BITS'(1);
      2:       return CFG_DATA_BITS'(WINDOW_MAX);
      3:       return CFG_DATA_BITS'($urandom_range(127, WINDOW_MAX + 1));
      4:       return CFG_DATA_BITS'(2);
      default: return CFG_DATA_BITS'($urandom_range(WINDOW_MAX, 1));
    endcase
  endfunction

  // Reset defaults: window of 8, plain mean, sample extremes
  task automatic test_plain_extremes();
    send_sample('{S_MAX, S_MIN, 16'sd0});
    send_sample('{S_MAX, S_MIN, -16'sd1});
    send_sample('{S_MIN, S_MAX, 16'sd1});
    send_sample('{-16'sd1, 16'sd1, S_MAX});
    send_sample('{16'sd7, -16'sd7, S_MIN});
    send_sample('{S_MAX, S_MAX, S_MAX});
  endtask

  // Weighted mean at the largest window and with a window of one
  task automatic test_weighted_extremes();
    write_register(REG_WINDOW_LENGTH, CFG_DATA_BITS'(WINDOW_MAX));
    write_register(REG_WEIGHTED_MODE, MODE_WEIGHTED);
    send_sample('{S_MAX, S_MIN, S_MAX});
    send_sample('{S_MAX, S_MIN, S_MIN});
    send_sample('{S_MIN, S_MAX, -16'sd1});
    send_sample('{16'sd1, -16'sd1, 16'sd0});
    write_register(REG_WINDOW_LENGTH, CFG_DATA_BITS'(1));
    send_sample('{S_MIN, S_MAX, -16'sd3});
    send_sample('{S_MAX, S_MIN, 16'sd3});
  endtask

  // Length zero and overlarge length, stray mode bits, unknown indexes,
  // and a rewrite of an unchanged value
  task automatic test_register_corners();
    write_register(REG_WINDOW_LENGTH, CFG_DATA_BITS'(0));
    send_sample('{S_MIN, 16'sd5, -16'sd5});
    send_sample('{S_MAX, -16'sd9, 16'sd9});
    write_register(REG_WINDOW_LENGTH, CFG_DATA_BITS'(127));
    write_register(REG_WEIGHTED_MODE, 7'h7E);
    send_sample('{S_MAX, S_MAX, S_MIN});
    send_sample('{-16'sd100, 16'sd100, S_MAX});
    write_register(REG_WEIGHTED_MODE, 7'h7F);
    write_register(REG_WINDOW_LENGTH, CFG_DATA_BITS'(3));
    send_sample('{16'sd300, -16'sd300, S_MIN});
    write_register(REG_UNUSED_2, 7'h55);
    write_register(REG_UNUSED_3, 7'h2A);
    send_sample('{16'sd11, -16'sd13, 16'sd17});
    send_sample('{S_MAX, S_MIN, 16'sd0});
    write_register(REG_WINDOW_LENGTH, CFG_DATA_BITS'(3));
    send_sample('{16'sd1, 16'sd2, 16'sd3});
  endtask

  // Random segments, each under a fresh setting most of the time
  task automatic test_random_stream(input int unsigned tx_pct, input int unsigned rx_pct,
                                    input int item_goal);
    int sent;
    int seg_len;
    int style;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(1)) begin
          write_register(REG_WINDOW_LENGTH, pick_window_length());
        end
        if ($urandom_range(1)) begin
          write_register(REG_WEIGHTED_MODE, CFG_DATA_BITS'($urandom));
        end
        if ($urandom_range(7) == 0) begin
          write_register($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3,
                         CFG_DATA_BITS'($urandom));
        end
      end
      // mostly mixed content, sometimes a run held at one extreme or at small values
      style = ($urandom_range(3) == 0) ? $urandom_range(2) : 3;
      seg_len = $urandom_range(140, 20);
      for (int k = 0; k < seg_len; k++) begin
        send_sample(random_sample(style));
      end
      sent += seg_len;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    win_len   = LEN_RESET;
    wmode     = 1'b0;
    clear_window();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_plain_extremes();
    test_weighted_extremes();
    test_register_corners();
    test_random_stream(30, 76, 400);
    test_random_stream(76, 30, 400);
    test_random_stream(0, 0, 400);

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_averages.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> vector_moving_average.f
rtl/vma_pkg.sv
rtl/vma_div.sv
rtl/vector_moving_average.sv
sim/tb.sv
